@@ src/stbs_pkg.sv @@
// stbs_pkg: types and constants shared by the sorted table bracket search block
// item structs, command and status codes, configuration register index
// no dependencies
package stbs_pkg;

    // fixed field widths
    localparam int VALUE_W     = 32;
    localparam int IDX_FIELD_W = 10;
    localparam int CNT_FIELD_W = 11;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] CFG_ENTRIES_IN_USE = 1'b0;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        STATUS_FOUND = 1'b0,
        STATUS_EMPTY = 1'b1
    } status_t;

    typedef struct packed {
        cmd_t                      command;
        logic [IDX_FIELD_W-1:0]    entry_index;
        logic signed [VALUE_W-1:0] entry_value;
        logic signed [VALUE_W-1:0] query_value;
    } cmd_item_t;

    typedef struct packed {
        status_t                   status;
        logic [IDX_FIELD_W-1:0]    lower_index;
        logic [IDX_FIELD_W-1:0]    upper_index;
        logic signed [VALUE_W-1:0] lower_entry;
        logic signed [VALUE_W-1:0] upper_entry;
    } res_item_t;

endpackage

@@ src/stbs_table_ram.sv @@
// stbs_table_ram: table storage, one write port and two registered read ports
// generic memory, no dependencies
module stbs_table_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re_a,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [DATA_W-1:0] rdata_a,
    input  logic              re_b,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem_array [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // read ports, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem_array[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem_array[raddr_b];
        end
    end

endmodule

@@ src/stbs_step_cell.sv @@
// stbs_step_cell: one lower-bound search step holding the current bounds
// compares the entry read at the midpoint and hands updated bounds on
// depends on stbs_pkg
module stbs_step_cell
    import stbs_pkg::*;
#(
    parameter int CNT_W = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] key,
    input  logic signed [VALUE_W-1:0] rd_data,
    input  logic                      in_act,
    input  logic [CNT_W-1:0]          in_lo,
    input  logic [CNT_W-1:0]          in_hi,
    output logic                      out_act,
    output logic [CNT_W-1:0]          out_lo,
    output logic [CNT_W-1:0]          out_hi
);

    logic             act_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] mid;

    // activity token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= in_act;
        end
    end

    // bounds taken from the neighbor
    always_ff @(posedge clk)
    begin
        if (in_act)
        begin
            lo_reg <= in_lo;
            hi_reg <= in_hi;
        end
    end

    // narrow the interval around the midpoint entry
    always_comb
    begin
        mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
        out_lo = lo_reg;
        out_hi = hi_reg;
        if (lo_reg < hi_reg)
        begin
            if (rd_data < key)
            begin
                out_lo = mid + CNT_W'(1);
            end
            else
            begin
                out_hi = mid;
            end
        end
    end

    assign out_act = act_reg;

endmodule

@@ src/sorted_table_bracket_search_core.sv @@
// sorted_table_bracket_search_core: ascending table with lower-bound bracket search
// depends on stbs_pkg, stbs_table_ram, stbs_step_cell
//
//   channel  | direction | handshake                  | payload
//   cmd      | in        | cmd_valid / cmd_stall      | cmd_item (cmd_item_t)
//   res      | out       | res_valid / res_stall      | res_item (res_item_t)
//   config   | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// a write item does not set cmd_stall; a query holds cmd_stall while the step cells
// run in turn, all sharing the table's read port, with both bracketing entries read while
// the last cell is active, then the result is loaded, which a stalled result ahead of it
// can delay; the next item is accepted once the result is loaded.
// reset clears the entry count and the control flags; the table is not cleared.
// a waiting result does not block acceptance; it holds the next query in the bracket stage.
module sorted_table_bracket_search_core
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_item_t          cmd_item,
    output logic               res_valid,
    input  logic               res_stall,
    output res_item_t          res_item
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int STEPS = CNT_W;

    logic [CNT_FIELD_W-1:0] entries_reg, entries_next;
    logic                   busy_reg, busy_next;
    logic                   bk_act_reg, bk_act_next;
    logic                   res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]       n_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic                   empty_reg;
    logic [IDX_W-1:0]       bk_li_reg, bk_ui_reg;
    res_item_t              res_item_reg, res_item_next;

    logic             cfg_write;
    logic             cmd_accept;
    logic             query_accept;
    logic             table_we;
    logic [CNT_W-1:0] n_cur;
    logic             out_load;

    logic [STEPS-1:0] cell_act;
    logic [CNT_W-1:0] cell_lo [STEPS];
    logic [CNT_W-1:0] cell_hi [STEPS];
    logic [CNT_W-1:0] sel_lo, sel_hi, sel_mid;
    logic [CNT_W-1:0] fin_lo, fin_hi;
    logic [IDX_W-1:0] li, ui;
    logic [IDX_W-1:0] raddr_a;
    logic             re_a;
    logic [VALUE_W-1:0] rdata_a, rdata_b;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == CFG_ENTRIES_IN_USE) ? PDATA_W'(entries_reg) : '0;

    always_comb
    begin
        entries_next = entries_reg;
        if (cfg_write && paddr[2] == CFG_ENTRIES_IN_USE)
        begin
            entries_next = pwdata[CNT_FIELD_W-1:0];
        end
    end

    // saturated entry count
    always_comb
    begin
        if (32'(entries_reg) > 32'(TABLE_DEPTH))
        begin
            n_cur = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_cur = CNT_W'(entries_reg);
        end
    end

    // command acceptance
    assign cmd_stall    = busy_reg;
    assign cmd_accept   = cmd_valid & ~cmd_stall;
    assign query_accept = cmd_accept && cmd_item.command == CMD_QUERY;
    assign table_we     = cmd_accept && cmd_item.command == CMD_WRITE
                          && 32'(cmd_item.entry_index) < 32'(TABLE_DEPTH);

    // query context
    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            n_reg     <= n_cur;
            key_reg   <= cmd_item.query_value;
            empty_reg <= (n_cur == '0);
        end
    end

    // chain of search step cells
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            stbs_step_cell #(
                .CNT_W(CNT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .key     (key_reg),
                .rd_data (rdata_a),
                .in_act  (query_accept),
                .in_lo   ('0),
                .in_hi   (n_cur),
                .out_act (cell_act[k]),
                .out_lo  (cell_lo[k]),
                .out_hi  (cell_hi[k])
            );
        end
        else
        begin : g_next
            stbs_step_cell #(
                .CNT_W(CNT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .key     (key_reg),
                .rd_data (rdata_a),
                .in_act  (cell_act[k-1]),
                .in_lo   (cell_lo[k-1]),
                .in_hi   (cell_hi[k-1]),
                .out_act (cell_act[k]),
                .out_lo  (cell_lo[k]),
                .out_hi  (cell_hi[k])
            );
        end
    end

    assign fin_lo = cell_lo[STEPS-1];
    assign fin_hi = cell_hi[STEPS-1];

    // bounds of the active cell, one-hot select
    always_comb
    begin
        sel_lo = '0;
        sel_hi = '0;
        for (int k = 0; k < STEPS - 1; k++)
        begin
            sel_lo = sel_lo | (cell_lo[k] & {CNT_W{cell_act[k]}});
            sel_hi = sel_hi | (cell_hi[k] & {CNT_W{cell_act[k]}});
        end
        sel_mid = sel_lo + ((sel_hi - sel_lo) >> 1);
    end

    // bracketing indices from the final bound
    always_comb
    begin
        if (n_reg == '0)
        begin
            li = '0;
            ui = '0;
        end
        else if (fin_lo == n_reg)
        begin
            li = IDX_W'(n_reg - CNT_W'(1));
            ui = IDX_W'(n_reg - CNT_W'(1));
        end
        else if (fin_lo == '0)
        begin
            li = '0;
            ui = '0;
        end
        else
        begin
            li = IDX_W'(fin_lo - CNT_W'(1));
            ui = IDX_W'(fin_lo);
        end
    end

    // read port a: first midpoint, then the next midpoint from each cell but the last, then lower entry
    always_comb
    begin
        if (query_accept)
        begin
            raddr_a = IDX_W'(n_cur >> 1);
        end
        else if (cell_act[STEPS-1])
        begin
            raddr_a = li;
        end
        else
        begin
            raddr_a = IDX_W'(sel_mid);
        end
    end

    assign re_a = query_accept | (|cell_act);

    stbs_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (VALUE_W)
    ) u_table (
        .clk     (clk),
        .we      (table_we),
        .waddr   (IDX_W'(cmd_item.entry_index)),
        .wdata   (cmd_item.entry_value),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .re_b    (cell_act[STEPS-1]),
        .raddr_b (ui),
        .rdata_b (rdata_b)
    );

    // bracket stage indices
    always_ff @(posedge clk)
    begin
        if (cell_act[STEPS-1])
        begin
            bk_li_reg <= li;
            bk_ui_reg <= ui;
        end
    end

    // control flags
    assign out_load = bk_act_reg & (~res_valid_reg | ~res_stall);

    always_comb
    begin
        busy_next      = busy_reg;
        bk_act_next    = bk_act_reg;
        res_valid_next = (res_valid_reg & res_stall) | out_load;
        if (query_accept)
        begin
            busy_next = 1'b1;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
        end
        if (cell_act[STEPS-1])
        begin
            bk_act_next = 1'b1;
        end
        else if (out_load)
        begin
            bk_act_next = 1'b0;
        end
    end

    // result item
    always_comb
    begin
        res_item_next = res_item_reg;
        if (out_load)
        begin
            if (empty_reg)
            begin
                res_item_next.status      = STATUS_EMPTY;
                res_item_next.lower_index = '0;
                res_item_next.upper_index = '0;
                res_item_next.lower_entry = '0;
                res_item_next.upper_entry = '0;
            end
            else
            begin
                res_item_next.status      = STATUS_FOUND;
                res_item_next.lower_index = IDX_FIELD_W'(bk_li_reg);
                res_item_next.upper_index = IDX_FIELD_W'(bk_ui_reg);
                res_item_next.lower_entry = rdata_a;
                res_item_next.upper_entry = rdata_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= '0;
            busy_reg      <= 1'b0;
            bk_act_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            entries_reg   <= entries_next;
            busy_reg      <= busy_next;
            bk_act_reg    <= bk_act_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // at most one search stage holds the query
    a_single_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cell_act, bk_act_reg}))
        else $error("more than one search stage active");

    // no stage active while the block is idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cell_act == '0) && !bk_act_reg)
        else $error("search stage active while idle");

    // the last cell always sees a closed interval
    a_converged: assert property (@(posedge clk) disable iff (!rst_n)
        cell_act[STEPS-1] |-> fin_lo == fin_hi)
        else $error("search did not converge in the cell chain");

    // found brackets are equal or adjacent indices
    a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status == STATUS_FOUND
        |-> (res_item.upper_index == res_item.lower_index)
            || (res_item.upper_index == res_item.lower_index + 10'd1))
        else $error("bracket indices not adjacent");

endmodule

@@ sim/testbench.sv @@
// testbench: self-checking bench for sorted_table_bracket_search_core
// loads ascending tables, runs bracket queries under random idling, checks every result
// depends on stbs_pkg and sorted_table_bracket_search_core
module testbench;
    import stbs_pkg::*;

    localparam int TABLE_SIZE    = 1024;
    localparam int STUCK_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 32;
    localparam int MAX_REPORTED  = 10;

    localparam logic [PADDR_W-1:0] ADDR_ENTRIES  = PADDR_W'(4 * CFG_ENTRIES_IN_USE);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4 * (CFG_ENTRIES_IN_USE + 1));

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = ~VAL_MIN;

    // table mirror, entry count and queue of brackets still owed by the block
    class bracket_tracker;
        logic signed [VALUE_W-1:0] tbl [TABLE_SIZE];
        logic [CNT_FIELD_W-1:0]    count;
        res_item_t                 pending_brackets [$];
        int unsigned               writes_seen, queries_seen, empty_queries;
        int unsigned               results_seen, mismatches, settings_seen;

        function new();
            count = '0;
            foreach (tbl[i]) tbl[i] = '0;
        endfunction

        function int unsigned live_entries();
            return (count > TABLE_SIZE) ? TABLE_SIZE : count;
        endfunction

        function int unsigned outstanding();
            return pending_brackets.size();
        endfunction

        function void write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
            if (addr == ADDR_ENTRIES)
            begin
                count = data[CNT_FIELD_W-1:0];
                settings_seen++;
            end
        endfunction

        // lower-bound search, then pick the bracketing pair
        function res_item_t lower_bound_bracket(logic signed [VALUE_W-1:0] x);
            int unsigned n, lo, hi, mid, li, ui;
            res_item_t   r;
            r = '0;
            n = live_entries();
            if (n == 0)
            begin
                r.status = STATUS_EMPTY;
                return r;
            end
            lo = 0;
            hi = n;
            while (lo < hi)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (tbl[mid] < x)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo == n)
            begin
                li = n - 1;
                ui = n - 1;
            end
            else if (lo == 0)
            begin
                li = 0;
                ui = 0;
            end
            else
            begin
                li = lo - 1;
                ui = lo;
            end
            r.status      = STATUS_FOUND;
            r.lower_index = li[IDX_FIELD_W-1:0];
            r.upper_index = ui[IDX_FIELD_W-1:0];
            r.lower_entry = tbl[li];
            r.upper_entry = tbl[ui];
            return r;
        endfunction

        // accepted item: store a write or queue the bracket a query owes
        function void note_command(cmd_item_t it);
            if (it.command == CMD_WRITE)
            begin
                tbl[it.entry_index] = it.entry_value;
                writes_seen++;
            end
            else
            begin
                queries_seen++;
                if (live_entries() == 0)
                    empty_queries++;
                pending_brackets.insert(pending_brackets.size(),
                                        lower_bound_bracket(it.query_value));
            end
        endfunction

        // accepted result against the oldest owed bracket
        function void check_bracket(res_item_t got);
            res_item_t want;
            bit        bad;
            string     tag;
            results_seen++;
            if (pending_brackets.size() == 0)
            begin
                want = '0;
                bad  = 1'b1;
                tag  = "no query waiting";
            end
            else
            begin
                want = pending_brackets.pop_front();
                tag  = "field";
                bad  = (got.status !== want.status) ||
                       (got.lower_index !== want.lower_index) ||
                       (got.upper_index !== want.upper_index) ||
                       (got.lower_entry !== want.lower_entry) ||
                       (got.upper_entry !== want.upper_entry);
            end
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("result mismatch (%s): expected st %0d idx %0d/%0d val %0d/%0d",
                             tag, want.status, want.lower_index, want.upper_index,
                             want.lower_entry, want.upper_entry,
                             "\n                got st %0d idx %0d/%0d val %0d/%0d",
                             got.status, got.lower_index, got.upper_index,
                             got.lower_entry, got.upper_entry);
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    cmd_item_t          cmd_item  = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_item_t          res_item;

    bracket_tracker tr = new();
    bit             calm        = 1'b0;
    int             stall_left  = 0;
    int             stuck_cycles = 0;

    sorted_table_bracket_search_core #(
        .TABLE_DEPTH(TABLE_SIZE)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver stalls in bursts of random length
    always @(negedge clk)
    begin
        if (!calm && stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (!calm && rst_n && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            tr.check_bracket(res_item);
    end

    // cycles without any accepted transfer
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
            (psel && penable && pready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    function automatic cmd_item_t make_write(int idx, logic signed [VALUE_W-1:0] v);
        cmd_item_t it;
        it.command     = CMD_WRITE;
        it.entry_index = idx[IDX_FIELD_W-1:0];
        it.entry_value = v;
        it.query_value = $urandom;
        return it;
    endfunction

    function automatic cmd_item_t make_query(logic signed [VALUE_W-1:0] x);
        cmd_item_t it;
        it.command     = CMD_QUERY;
        it.entry_index = IDX_FIELD_W'($urandom_range(0, TABLE_SIZE - 1));
        it.entry_value = $urandom;
        it.query_value = x;
        return it;
    endfunction

    // query value near table contents, random, zero or at the range ends
    function automatic logic signed [VALUE_W-1:0] pick_probe();
        int unsigned               n;
        logic signed [VALUE_W-1:0] base;
        n    = tr.live_entries();
        base = (n == 0) ? $urandom : tr.tbl[$urandom_range(0, n - 1)];
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return base;
            3:       return base + 1;
            4:       return base - 1;
            default:
                case ($urandom_range(0, 2))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    default: return '0;
                endcase
        endcase
    endfunction

    // value that keeps the neighborhood ascending, or now and then any value
    function automatic logic signed [VALUE_W-1:0] fitting_value(int idx);
        longint lo_v, hi_v;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        lo_v = (idx > 0) ? longint'(tr.tbl[idx - 1]) : longint'(VAL_MIN);
        hi_v = (idx < TABLE_SIZE - 1) ? longint'(tr.tbl[idx + 1]) : longint'(VAL_MAX);
        if (hi_v < lo_v)
            return lo_v[VALUE_W-1:0];
        lo_v = lo_v + (longint'($urandom) % (hi_v - lo_v + 1));
        return lo_v[VALUE_W-1:0];
    endfunction

    // present one item, with an occasional gap before it, and wait for acceptance
    task automatic push_item(input cmd_item_t it);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        tr.note_command(it);
    endtask

    // stop sending, wait for every owed bracket, let the block go idle
    task automatic settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (tr.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tr.write_register(addr, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // empty table, small hand-made tables, ignored register, duplicates
    task automatic run_directed();
        logic signed [VALUE_W-1:0] probes [7];
        probes = '{VAL_MIN, -6, -5, 0, 100, 101, VAL_MAX};
        apb_write(ADDR_ENTRIES, 0);
        push_item(make_query(0));
        push_item(make_query(VAL_MIN));
        push_item(make_query(VAL_MAX));
        push_item(make_write(0, VAL_MIN));
        push_item(make_write(1, -5));
        push_item(make_write(2, 100));
        push_item(make_write(3, VAL_MAX - 1));
        settle();
        apb_write(ADDR_ENTRIES, 4);
        foreach (probes[i])
            push_item(make_query(probes[i]));
        settle();
        apb_write(ADDR_UNMAPPED, 1);
        push_item(make_query(0));
        settle();
        apb_write(ADDR_ENTRIES, 1);
        push_item(make_query(VAL_MIN));
        push_item(make_query(5));
        push_item(make_write(1, VAL_MIN));
        settle();
        apb_write(ADDR_ENTRIES, 2);
        push_item(make_query(VAL_MIN));
        push_item(make_query(0));
    endtask

    // fill the whole table in ascending order, widening the count every 128 entries
    task automatic run_fill();
        logic signed [VALUE_W-1:0] v, prev;
        longint                    lv;
        prev = VAL_MIN;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (i == 0)
                v = VAL_MIN;
            else if (i == TABLE_SIZE - 1)
                v = VAL_MAX;
            else if ($urandom_range(0, 15) == 0)
                v = prev;
            else
            begin
                lv = longint'(VAL_MIN) + longint'(i) * 4194304 +
                     longint'($urandom_range(0, 4194303));
                v  = lv[VALUE_W-1:0];
            end
            prev = v;
            push_item(make_write(i, v));
            if ($urandom_range(0, 7) == 0)
                push_item(make_query(pick_probe()));
            if (i % 128 == 127)
            begin
                settle();
                apb_write(ADDR_ENTRIES, i + 1);
            end
        end
    endtask

    // one count setting followed by a mix of queries and table updates
    task automatic run_round(input logic [PDATA_W-1:0] setting, input int items);
        int idx;
        settle();
        apb_write(ADDR_ENTRIES, setting);
        repeat (items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                idx = $urandom_range(0, TABLE_SIZE - 1);
                push_item(make_write(idx, fitting_value(idx)));
            end
            else
                push_item(make_query(pick_probe()));
        end
    endtask

    initial
    begin
        bit          timed_out;
        bit          failed;
        int unsigned leftover;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        fork
            begin
                run_directed();
                run_fill();
                run_round(32'hFFFF_FFFF, 50);
                run_round(TABLE_SIZE + 1, 50);
                run_round(1, 50);
                run_round(2, 50);
                run_round(0, 10);
                run_round($urandom_range(3, TABLE_SIZE - 1), 50);
                run_round($urandom_range(3, TABLE_SIZE - 1), 50);
                run_round(TABLE_SIZE / 2, 40);
                // last stretch runs with no idling on either side
                calm = 1'b1;
                run_round(TABLE_SIZE, 60);
                @(negedge clk);
                cmd_valid <= 1'b0;
                while (tr.outstanding() != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                wait (stuck_cycles >= STUCK_LIMIT);
            end
        join_any
        timed_out = (stuck_cycles >= STUCK_LIMIT);
        leftover  = tr.outstanding();
        if (timed_out)
            $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
        if (leftover != 0)
            $display("%0d query results never arrived", leftover);
        if (tr.mismatches > MAX_REPORTED)
            $display("%0d mismatches in total", tr.mismatches);
        $display("run: %0d table writes, %0d queries (%0d on an empty table), %0d results",
                 tr.writes_seen, tr.queries_seen, tr.empty_queries, tr.results_seen);
        $display("     checked over %0d entry count settings, saturated and zero included",
                 tr.settings_seen);
        failed = timed_out || (leftover != 0) || (tr.mismatches != 0);
        if (!failed)
            $display("** sorted_table_bracket_search_core: PASSED **");
        else
            $display("** sorted_table_bracket_search_core: FAILED **");
        $finish;
    end

endmodule
